// ===== rtl/playback_position_transport_core_macros.svh =====
// Assertion macros for the playback position transport core.
// Bodies are empty when SYNTH is defined; clock and reset come from the including module.
`ifndef PLAYBACK_POSITION_TRANSPORT_CORE_MACROS_SVH
`define PLAYBACK_POSITION_TRANSPORT_CORE_MACROS_SVH
`ifndef SYNTH
`define PPT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define PPT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PPT_ASSERT_IMP(label, ante, cons, msg)
`define PPT_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/ppt_pkg.sv =====
// Shared types and constants of the playback position transport core.
// No dependencies.
package ppt_pkg;

  localparam int TIME_W   = 40;
  localparam int SPEED_W  = 16;
  localparam int FPS_W    = 24;
  localparam int PERIOD_W = 17;
  localparam int SUM_W    = 43;
  localparam int NUM_W    = 42;

  localparam logic [SPEED_W-1:0]  SPEED_MIN  = 16'd256;
  localparam logic [SPEED_W-1:0]  SPEED_MAX  = 16'd32768;
  localparam logic [SPEED_W-1:0]  SPEED_RST  = 16'd4096;
  localparam logic [FPS_W-1:0]    FPS_MIN    = 24'd65536;
  localparam logic [FPS_W-1:0]    FPS_MAX    = 24'd15728640;
  localparam logic [FPS_W-1:0]    FPS_RST    = 24'd1572864;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN = 17'd273;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 17'd65536;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 17'd2731;

  typedef enum logic [3:0] {
    FN_TICK   = 4'd0,
    FN_PLAY   = 4'd1,
    FN_PAUSE  = 4'd2,
    FN_TOGGLE = 4'd3,
    FN_SEEK   = 4'd4,
    FN_REL    = 4'd5,
    FN_STEP   = 4'd6,
    FN_START  = 4'd7,
    FN_END    = 4'd8
  } func_e;

  typedef enum logic [2:0] {
    REG_CLIP   = 3'd0,
    REG_LSTART = 3'd1,
    REG_LEND   = 3'd2,
    REG_LEN    = 3'd3,
    REG_SPEED  = 3'd4,
    REG_FPS    = 3'd5,
    REG_PERIOD = 3'd6,
    REG_LOCKED = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FLO, ST_FHI, ST_FSUM, ST_MUL, ST_SUM, ST_APPLY, ST_DIV, ST_FIX, ST_DONE
  } state_e;

endpackage

// ===== rtl/playback_position_transport_core.sv =====
// Playback position transport core: config registers, sequencer and shared datapath.
// A word steps through the frame lookup of the old position, multiply, sum and apply, then the
// frame lookup of the new position; a loop or clip wrap first runs the bit-serial remainder
// (42 steps plus a fix-up step). One word is handled at a time; the input is stalled until the
// result is handed to the output register. The frame index is built from two 20x24 partial
// products on the one shared multiplier. Reset clears position, play and skip flags and loads defaults.
`include "playback_position_transport_core_macros.svh"

module playback_position_transport_core import ppt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [3:0]           func_i,
  input  logic [23:0]          elapsed_i,
  input  logic signed [40:0]   seek_time_i,
  input  logic signed [15:0]   step_frames_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [TIME_W-1:0]    position_o,
  output logic [31:0]          frame_index_o,
  output logic                 frame_changed_o,
  output logic                 position_changed_o,
  output logic                 is_playing_o,
  output logic                 playing_changed_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [5:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);

  // configuration
  logic [TIME_W-1:0]   clip_q, lstart_q, lend_q;
  logic                len_q, locked_q;
  logic [SPEED_W-1:0]  speed_q;
  logic [FPS_W-1:0]    fps_q;
  logic [PERIOD_W-1:0] period_q;
  logic                cfg_wr;
  cfg_reg_e            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = cfg_reg_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q   <= '0;
      lstart_q <= '0;
      lend_q   <= '0;
      len_q    <= 1'b0;
      speed_q  <= SPEED_RST;
      fps_q    <= FPS_RST;
      period_q <= PERIOD_RST;
      locked_q <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CLIP:   clip_q   <= pwdata[TIME_W-1:0];
        REG_LSTART: lstart_q <= pwdata[TIME_W-1:0];
        REG_LEND:   lend_q   <= pwdata[TIME_W-1:0];
        REG_LEN:    len_q    <= pwdata[0];
        REG_SPEED: begin
          if (pwdata[15:0] < SPEED_MIN)      speed_q <= SPEED_MIN;
          else if (pwdata[15:0] > SPEED_MAX) speed_q <= SPEED_MAX;
          else                               speed_q <= pwdata[15:0];
        end
        REG_FPS: begin
          if (pwdata[23:0] < FPS_MIN)      fps_q <= FPS_MIN;
          else if (pwdata[23:0] > FPS_MAX) fps_q <= FPS_MAX;
          else                             fps_q <= pwdata[23:0];
        end
        REG_PERIOD: begin
          if (pwdata[16:0] < PERIOD_MIN)      period_q <= PERIOD_MIN;
          else if (pwdata[16:0] > PERIOD_MAX) period_q <= PERIOD_MAX;
          else                                period_q <= pwdata[16:0];
        end
        REG_LOCKED: locked_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CLIP:   prdata = 64'(clip_q);
      REG_LSTART: prdata = 64'(lstart_q);
      REG_LEND:   prdata = 64'(lend_q);
      REG_LEN:    prdata = 64'(len_q);
      REG_SPEED:  prdata = 64'(speed_q);
      REG_FPS:    prdata = 64'(fps_q);
      REG_PERIOD: prdata = 64'(period_q);
      REG_LOCKED: prdata = 64'(locked_q);
      default:    prdata = '0;
    endcase
  end

  // sequencer and datapath state
  state_e state_q, state_d;
  logic [TIME_W-1:0] pos_q, pos_d;
  logic run_q, run_d, skip_q, skip_d, was_run_q;
  logic pchg_q, pchg_d, new_q, new_d;
  logic [3:0] func_q;
  logic [23:0] elapsed_q;
  logic signed [40:0] seek_q;
  logic signed [15:0] step_q;
  logic signed [49:0] prod_q;
  logic [43:0] acc_q;
  logic [31:0] old_frame_q, frame_q, frame_c;
  logic [64:0] fsum;
  logic signed [SUM_W-1:0] t_q, t_d, pos_s;
  logic [40:0] delta;
  logic [TIME_W-1:0] clamp_c;
  logic [41:0] tu;
  logic [NUM_W-1:0] num_q, num_d;
  logic [TIME_W-1:0] den_q, den_d, base_q, base_d, rem_q;
  logic [40:0] rem_sh;
  logic sub_q, sub_d, go_div;
  logic [5:0] cnt_q;
  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] mul_p;
  logic in_acc, out_free;
  logic out_valid_q;
  logic [TIME_W-1:0] out_pos_q;
  logic [31:0] out_frame_q;
  logic out_fchg_q, out_pchg_q, out_play_q, out_plchg_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = 25'(fps_q);
    case (state_q)
      ST_FLO: mul_a = 25'(pos_q[19:0]);
      ST_FHI: mul_a = 25'(pos_q[39:20]);
      ST_MUL: begin
        if (func_q == FN_STEP) begin
          mul_a = 25'(step_q);
          mul_b = 25'(period_q);
        end else begin
          mul_a = 25'(elapsed_q);
          mul_b = 25'(speed_q);
        end
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // frame index: round half up, saturate
  assign fsum    = 65'(acc_q) + (65'(prod_q[43:0]) << 20) + 65'h8000_0000;
  assign frame_c = fsum[64] ? 32'hFFFF_FFFF : fsum[63:32];

  assign pos_s = SUM_W'(pos_q);
  assign delta = 41'(prod_q[39:0]) + 41'd2048;
  assign tu    = t_q[41:0];

  always_comb begin
    if (t_q[SUM_W-1])                    clamp_c = '0;
    else if (clip_q != '0 && tu > 42'(clip_q)) clamp_c = clip_q;
    else if (tu[41:40] != 2'b00)         clamp_c = '1;
    else                                 clamp_c = tu[TIME_W-1:0];
  end

  assign rem_sh = {rem_q, num_q[NUM_W-1]};

  // datapath next values
  always_comb begin
    pos_d  = pos_q;
    run_d  = run_q;
    skip_d = skip_q;
    pchg_d = pchg_q;
    new_d  = new_q;
    t_d    = t_q;
    num_d  = num_q;
    den_d  = den_q;
    base_d = base_q;
    sub_d  = sub_q;
    go_div = 1'b0;
    case (state_q)
      ST_IDLE: begin
        pchg_d = 1'b0;
        new_d  = 1'b0;
      end
      ST_SUM: begin
        case (func_q)
          FN_TICK: begin
            if (locked_q) t_d = pos_s + SUM_W'(period_q);
            else          t_d = pos_s + SUM_W'(delta[40:12]);
          end
          FN_SEEK:  t_d = SUM_W'(seek_q);
          FN_REL:   t_d = pos_s + SUM_W'(seek_q);
          FN_STEP:  t_d = pos_s + SUM_W'($signed(prod_q[32:0]));
          FN_START: t_d = '0;
          FN_END:   t_d = SUM_W'(clip_q);
          default:  t_d = t_q;
        endcase
      end
      ST_APPLY: begin
        new_d = 1'b1;
        case (func_q)
          FN_TICK: begin
            if (!run_q) begin
              skip_d = 1'b0;
            end else if (locked_q) begin
              pos_d  = clamp_c;
              pchg_d = 1'b1;
            end else if (skip_q) begin
              skip_d = 1'b0;
            end else if (elapsed_q != '0) begin
              pchg_d = 1'b1;
              if (len_q && lend_q > lstart_q) begin
                den_d = lend_q - lstart_q;
                if (tu >= 42'(lend_q)) begin
                  go_div = 1'b1;
                  num_d  = tu - 42'(lstart_q);
                  base_d = lstart_q;
                  sub_d  = 1'b0;
                end else if (tu < 42'(lstart_q)) begin
                  go_div = 1'b1;
                  num_d  = 42'(lstart_q) - tu;
                  base_d = lend_q;
                  sub_d  = 1'b1;
                end else begin
                  pos_d = tu[TIME_W-1:0];
                end
              end else if (len_q && clip_q != '0) begin
                den_d = clip_q;
                if (tu >= 42'(clip_q)) begin
                  go_div = 1'b1;
                  num_d  = tu;
                  base_d = '0;
                  sub_d  = 1'b0;
                end else begin
                  pos_d = tu[TIME_W-1:0];
                end
              end else begin
                pos_d = clamp_c;
              end
            end
          end
          FN_PLAY: begin
            if (!run_q) begin
              run_d  = 1'b1;
              skip_d = 1'b1;
            end
          end
          FN_PAUSE: run_d = 1'b0;
          FN_TOGGLE: begin
            run_d = ~run_q;
            if (!run_q) skip_d = 1'b1;
          end
          FN_SEEK, FN_REL, FN_STEP, FN_START, FN_END: begin
            if (func_q != FN_STEP || step_q != '0) begin
              if (func_q == FN_STEP) run_d = 1'b0;
              if (clamp_c != pos_q) begin
                pos_d  = clamp_c;
                skip_d = 1'b1;
                pchg_d = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      ST_DIV: num_d = num_q << 1;
      ST_FIX: pos_d = sub_q ? base_q - rem_q : base_q + rem_q;
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_FLO;
      ST_FLO:   state_d = ST_FHI;
      ST_FHI:   state_d = ST_FSUM;
      ST_FSUM:  state_d = new_q ? ST_DONE : ST_MUL;
      ST_MUL:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_APPLY;
      ST_APPLY: state_d = go_div ? ST_DIV : ST_FLO;
      ST_DIV:   if (cnt_q == 6'(NUM_W - 1)) state_d = ST_FIX;
      ST_FIX:   state_d = ST_FLO;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      run_q       <= 1'b0;
      skip_q      <= 1'b0;
      pchg_q      <= 1'b0;
      new_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      run_q   <= run_d;
      skip_q  <= skip_d;
      pchg_q  <= pchg_d;
      new_q   <= new_d;
      if (state_q == ST_DIV) cnt_q <= cnt_q + 6'd1;
      else                   cnt_q <= '0;
      if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i)              out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q    <= func_i;
      elapsed_q <= elapsed_i;
      seek_q    <= seek_time_i;
      step_q    <= step_frames_i;
      was_run_q <= run_q;
    end
    prod_q <= mul_p;
    if (state_q == ST_FHI) acc_q <= prod_q[43:0];
    if (state_q == ST_FSUM) begin
      if (new_q) frame_q     <= frame_c;
      else       old_frame_q <= frame_c;
    end
    t_q    <= t_d;
    num_q  <= num_d;
    den_q  <= den_d;
    base_q <= base_d;
    sub_q  <= sub_d;
    if (state_q == ST_APPLY) begin
      rem_q <= '0;
    end else if (state_q == ST_DIV) begin
      // restoring step: one quotient bit per cycle, keep the remainder
      if (rem_sh >= 41'(den_q)) rem_q <= TIME_W'(rem_sh - 41'(den_q));
      else                      rem_q <= rem_sh[TIME_W-1:0];
    end
    if (state_q == ST_DONE && out_free) begin
      out_pos_q   <= pos_q;
      out_frame_q <= frame_q;
      out_fchg_q  <= (frame_q != old_frame_q);
      out_pchg_q  <= pchg_q;
      out_play_q  <= run_q;
      out_plchg_q <= (run_q != was_run_q);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign position_o         = out_pos_q;
  assign frame_index_o      = out_frame_q;
  assign frame_changed_o    = out_fchg_q;
  assign position_changed_o = out_pchg_q;
  assign is_playing_o       = out_play_q;
  assign playing_changed_o  = out_plchg_q;

  `PPT_ASSERT_NXT(a_accept_starts_frame, in_acc, state_q == ST_FLO, "accept did not start")
  `PPT_ASSERT_IMP(a_frame_needs_move, out_valid_o && !position_changed_o, !frame_changed_o, "frame moved")
  `PPT_ASSERT_IMP(a_div_bounded, state_q == ST_DIV, cnt_q < 6'(NUM_W), "remainder step overran")
  `PPT_ASSERT_IMP(a_fix_in_loop, state_q == ST_FIX && !sub_q, rem_q < den_q, "remainder too big")

endmodule

// ===== bench/playback_position_transport_core_test.sv =====
// Testbench for the playback position transport core: directed table, then random phases.
// Depends on ppt_pkg and the core; checks each result word against a built-in predictor.
module playback_position_transport_core_test;
  import ppt_pkg::*;

  typedef struct packed {
    logic [TIME_W-1:0] pos;
    logic [31:0]       frame;
    logic              frame_chg;
    logic              pos_chg;
    logic              playing;
    logic              play_chg;
  } outcome_t;

  typedef struct {
    logic [3:0]         fn;
    logic [23:0]        elapsed;
    logic signed [40:0] seek;
    logic signed [15:0] step;
    bit                 typed;
    outcome_t           res;
  } cmd_row_t;

  localparam longint unsigned TIME_TOP = (64'd1 << TIME_W) - 1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [3:0] func_i = '0;
  logic [23:0] elapsed_i = '0;
  logic signed [40:0] seek_time_i = '0;
  logic signed [15:0] step_frames_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [TIME_W-1:0] position_o;
  logic [31:0] frame_index_o;
  logic frame_changed_o, position_changed_o, is_playing_o, playing_changed_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  playback_position_transport_core DUT (.*);

  always #4 clk_i = ~clk_i;

  // predictor state and register copies
  logic [TIME_W-1:0]   cur_pos;
  logic                running, skip_armed;
  logic [TIME_W-1:0]   clip_r, lstart_r, lend_r;
  logic                loop_en_r, locked_r;
  logic [SPEED_W-1:0]  speed_r;
  logic [FPS_W-1:0]    fps_r;
  logic [PERIOD_W-1:0] period_r;

  outcome_t expected_q[$];
  cmd_row_t dir_rows[$];
  bit failed = 1'b0;
  bit calm = 1'b0;
  int gap_max = 3;
  int hold_cycles = 0;

  function automatic logic [31:0] frame_at(logic [TIME_W-1:0] p);
    logic [65:0] prod;
    prod = 66'(p) * 66'(fps_r) + (66'd1 << 31);
    return (prod[65:32] > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[63:32];
  endfunction

  function automatic longint unsigned clamp_t(longint t);
    longint unsigned u;
    if (t < 0) return 0;
    u = t;
    if (clip_r != 0 && u > clip_r) u = clip_r;
    if (u > TIME_TOP) u = TIME_TOP;
    return u;
  endfunction

  function automatic bit seek_to(longint t);
    longint unsigned tgt;
    tgt = clamp_t(t);
    if (tgt == cur_pos) return 1'b0;
    cur_pos = TIME_W'(tgt);
    skip_armed = 1'b1;
    return 1'b1;
  endfunction

  function automatic longint unsigned wrap_pos(longint unsigned p);
    longint unsigned span;
    if (loop_en_r && lend_r > lstart_r) begin
      span = 64'(lend_r - lstart_r);
      if (p >= lend_r) return lstart_r + (p - lstart_r) % span;
      if (p < lstart_r) return lend_r - (lstart_r - p) % span;
      return p;
    end
    if (loop_en_r && clip_r != 0) begin
      if (p >= clip_r) return p % clip_r;
      return p;
    end
    return clamp_t(longint'(p));
  endfunction

  function automatic outcome_t transport_apply(logic [3:0] fn, logic [23:0] el,
                                               logic signed [40:0] sk,
                                               logic signed [15:0] st);
    outcome_t r;
    logic [31:0] old_frame;
    logic was_running;
    longint unsigned delta;
    bit moved;
    old_frame = frame_at(cur_pos);
    was_running = running;
    moved = 1'b0;
    case (fn)
      FN_TICK: begin
        if (!running) begin
          skip_armed = 1'b0;
        end else if (locked_r) begin
          cur_pos = TIME_W'(clamp_t(longint'(cur_pos) + longint'(period_r)));
          moved = 1'b1;
        end else if (skip_armed) begin
          skip_armed = 1'b0;
        end else if (el != 0) begin
          delta = (longint'(el) * longint'(speed_r) + 2048) >> 12;
          cur_pos = TIME_W'(wrap_pos(longint'(cur_pos) + delta));
          moved = 1'b1;
        end
      end
      FN_PLAY: begin
        if (!running) begin
          running = 1'b1;
          skip_armed = 1'b1;
        end
      end
      FN_PAUSE: running = 1'b0;
      FN_TOGGLE: begin
        if (running) begin
          running = 1'b0;
        end else begin
          running = 1'b1;
          skip_armed = 1'b1;
        end
      end
      FN_SEEK: moved = seek_to(longint'(sk));
      FN_REL: moved = seek_to(longint'(cur_pos) + longint'(sk));
      FN_STEP: begin
        if (st != 0) begin
          running = 1'b0;
          moved = seek_to(longint'(cur_pos) + longint'(st) * longint'(period_r));
        end
      end
      FN_START: moved = seek_to(0);
      FN_END: moved = seek_to(longint'(clip_r));
      default: ;
    endcase
    r.pos = cur_pos;
    r.frame = frame_at(cur_pos);
    r.frame_chg = (r.frame != old_frame);
    r.pos_chg = moved;
    r.playing = running;
    r.play_chg = (running != was_running);
    return r;
  endfunction

  function automatic void cfg_store(cfg_reg_e idx, logic [63:0] v);
    case (idx)
      REG_CLIP:   clip_r = v[TIME_W-1:0];
      REG_LSTART: lstart_r = v[TIME_W-1:0];
      REG_LEND:   lend_r = v[TIME_W-1:0];
      REG_LEN:    loop_en_r = v[0];
      REG_SPEED:  speed_r = (v[15:0] < SPEED_MIN) ? SPEED_MIN :
                            (v[15:0] > SPEED_MAX) ? SPEED_MAX : v[15:0];
      REG_FPS:    fps_r = (v[23:0] < FPS_MIN) ? FPS_MIN :
                          (v[23:0] > FPS_MAX) ? FPS_MAX : v[23:0];
      REG_PERIOD: period_r = (v[16:0] < PERIOD_MIN) ? PERIOD_MIN :
                             (v[16:0] > PERIOD_MAX) ? PERIOD_MAX : v[16:0];
      REG_LOCKED: locked_r = v[0];
      default: ;
    endcase
  endfunction

  task automatic reg_write(cfg_reg_e idx, logic [63:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 6'(idx) << 3;
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    cfg_store(idx, v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_word(logic [3:0] fn, logic [23:0] el, logic signed [40:0] sk,
                           logic signed [15:0] st, bit typed, outcome_t typed_res);
    outcome_t r;
    int gap;
    func_i <= fn;
    elapsed_i <= el;
    seek_time_i <= sk;
    step_frames_i <= st;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = transport_apply(fn, el, sk, st);
    expected_q.push_back(typed ? typed_res : r);
    gap = 0;
    if (!calm && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic void add_row(logic [3:0] fn, logic [23:0] el, logic signed [40:0] sk,
                                  logic signed [15:0] st, bit typed = 1'b0,
                                  outcome_t res = '0);
    cmd_row_t row;
    row.fn = fn;
    row.elapsed = el;
    row.seek = sk;
    row.step = st;
    row.typed = typed;
    row.res = res;
    dir_rows.push_back(row);
  endfunction

  task automatic phase_config(int p);
    logic [TIME_W-1:0] clip, ls, le;
    clip = ($urandom_range(0, 3) == 0) ? TIME_W'({$urandom, $urandom}) :
                                          TIME_W'($urandom_range(1000, 4000000));
    ls = TIME_W'($urandom_range(0, 1000000));
    le = ls + TIME_W'($urandom_range(0, 2000000));
    if (p == 1) begin
      clip = 0;
    end else if (p == 2) begin
      clip = '1;
      ls = '1;
      le = 0;
    end else if (p == 3) begin
      le = ls;
    end
    reg_write(REG_CLIP, {$urandom, $urandom} & 64'(clip) | 64'(clip));
    reg_write(REG_LSTART, 64'(ls));
    reg_write(REG_LEND, 64'(le));
    reg_write(REG_LEN, (p == 2) ? 64'd0 : 64'(p != 4 || $urandom_range(0, 1)));
    reg_write(REG_SPEED, (p == 1) ? 64'd0 : (p == 2) ? 64'hFFFF : 64'($urandom));
    reg_write(REG_FPS, (p == 1) ? 64'd0 : (p == 2) ? 64'hFF_FFFF : 64'($urandom));
    reg_write(REG_PERIOD, (p == 1) ? 64'd0 : (p == 2) ? 64'h1_FFFF : 64'($urandom));
    reg_write(REG_LOCKED, 64'(p == 2 || p == 6));
  endtask

  task automatic random_word();
    logic [3:0] fn;
    logic [23:0] el;
    logic signed [40:0] sk;
    logic signed [15:0] st;
    int r;
    r = $urandom_range(0, 99);
    fn = (r < 45) ? FN_TICK : (r < 53) ? FN_PLAY : (r < 56) ? FN_PAUSE :
         (r < 60) ? FN_TOGGLE : (r < 70) ? FN_SEEK : (r < 78) ? FN_REL :
         (r < 86) ? FN_STEP : (r < 90) ? FN_START : (r < 94) ? FN_END :
         4'($urandom_range(0, 15));
    r = $urandom_range(0, 9);
    el = (r == 0) ? 24'd0 : (r == 1) ? 24'($urandom) : 24'($urandom_range(1, 200000));
    sk = ($urandom_range(0, 2) == 0) ? 41'({$urandom, $urandom}) :
         41'($urandom_range(0, 4000000)) - 41'($urandom_range(0, 2000000) *
         (fn == FN_REL));
    st = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20)) - 16'sd10;
    send_word(fn, el, sk, st, 1'b0, '0);
  endtask

  // receiver: random stalls plus long hold-offs on request
  int stall_left = 0;
  always @(posedge clk_i) begin
    outcome_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result word: position %0h", position_o);
        failed = 1'b1;
      end else begin
        want = expected_q.pop_front();
        if (position_o !== want.pos) begin
          $error("position: expected %0h actual %0h", want.pos, position_o);
          failed = 1'b1;
        end
        if (frame_index_o !== want.frame) begin
          $error("frame_index: expected %0h actual %0h", want.frame, frame_index_o);
          failed = 1'b1;
        end
        if (frame_changed_o !== want.frame_chg) begin
          $error("frame_changed: expected %0b actual %0b", want.frame_chg, frame_changed_o);
          failed = 1'b1;
        end
        if (position_changed_o !== want.pos_chg) begin
          $error("position_changed: expected %0b actual %0b", want.pos_chg,
                 position_changed_o);
          failed = 1'b1;
        end
        if (is_playing_o !== want.playing) begin
          $error("is_playing: expected %0b actual %0b", want.playing, is_playing_o);
          failed = 1'b1;
        end
        if (playing_changed_o !== want.play_chg) begin
          $error("playing_changed: expected %0b actual %0b", want.play_chg,
                 playing_changed_o);
          failed = 1'b1;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    #5_000_000;
    $display("playback_position_transport_core: mismatch");
    $finish;
  end

  initial begin
    outcome_t res;
    cur_pos = '0;
    running = 1'b0;
    skip_armed = 1'b0;
    clip_r = '0;
    lstart_r = '0;
    lend_r = '0;
    loop_en_r = 1'b0;
    locked_r = 1'b0;
    speed_r = SPEED_RST;
    fps_r = FPS_RST;
    period_r = PERIOD_RST;

    // paused tick after reset, then seeks to both ends of the time range
    add_row(FN_TICK, 24'hFF_FFFF, 41'sd0, 16'sd0, 1'b1, '0);
    res = '{pos: TIME_W'(TIME_TOP), frame: 32'd402653184, frame_chg: 1'b1, pos_chg: 1'b1,
            playing: 1'b0, play_chg: 1'b0};
    add_row(FN_SEEK, 24'd0, 41'sh0FF_FFFF_FFFF, 16'sd0, 1'b1, res);
    res = '{pos: '0, frame: 32'd0, frame_chg: 1'b1, pos_chg: 1'b1,
            playing: 1'b0, play_chg: 1'b0};
    add_row(FN_SEEK, 24'd0, -41'sh100_0000_0000, 16'sd0, 1'b1, res);
    add_row(FN_START, 24'd0, 41'sd0, 16'sd0);
    add_row(FN_PLAY, 24'd0, 41'sd0, 16'sd0);
    add_row(FN_PLAY, 24'd0, 41'sd0, 16'sd0);
    add_row(FN_TICK, 24'd5000, 41'sd0, 16'sd0);
    add_row(FN_TICK, 24'd0, 41'sd0, 16'sd0);
    add_row(FN_TICK, 24'd70000, 41'sd0, 16'sd0);
    add_row(FN_TICK, 24'hFF_FFFF, 41'sd0, 16'sd0);
    add_row(FN_REL, 24'd0, 41'sd123456, 16'sd0);
    add_row(FN_REL, 24'd0, -41'sd100000000, 16'sd0);
    add_row(FN_SEEK, 24'd0, 41'sd0, 16'sd0);
    add_row(FN_TOGGLE, 24'd0, 41'sd0, 16'sd0);
    add_row(FN_TOGGLE, 24'd0, 41'sd0, 16'sd0);
    add_row(FN_STEP, 24'd0, 41'sd0, 16'sd0);
    add_row(FN_STEP, 24'd0, 41'sd0, 16'sd5);
    add_row(FN_STEP, 24'd0, 41'sd0, 16'sh7FFF);
    add_row(FN_STEP, 24'd0, 41'sd0, -16'sh8000);
    add_row(FN_END, 24'd0, 41'sd0, 16'sd0);
    add_row(FN_PAUSE, 24'd0, 41'sd0, 16'sd0);
    add_row(4'd9, 24'd0, 41'sd0, 16'sd0);
    add_row(4'd15, 24'hFF_FFFF, -41'sd1, -16'sd1);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_word(dir_rows[i].fn, dir_rows[i].elapsed, dir_rows[i].seek, dir_rows[i].step,
                dir_rows[i].typed, dir_rows[i].res);
    drain();

    for (int p = 0; p < 8; p++) begin
      phase_config(p);
      calm = (p == 5);
      gap_max = (p % 2) ? 6 : 2;
      send_word(FN_PLAY, 24'd0, 41'sd0, 16'sd0, 1'b0, '0);
      for (int n = 0; n < 48; n++) begin
        // hold the output long enough that the core backs up into its input
        if (p == 3 && n == 10) hold_cycles = 300;
        random_word();
      end
      drain();
    end

    if (!failed) begin
      $display("playback_position_transport_core: match");
    end else begin
      $display("playback_position_transport_core: mismatch");
    end
    $finish;
  end

endmodule
